FILE: rtl/core/wavhp_pkg.sv
// Shared widths, codes and header constants for the WAV header parser.
package wavhp_pkg;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int FRAME_W = 16;
   localparam int COUNT_W = 31;
   localparam int ERR_W   = 4;
   localparam int RATE_W  = 32;
   localparam int POS_W   = 6;
   localparam int ACC_W   = 32;

   // sample rate after reset
   localparam logic [RATE_W-1:0] RATE_RESET = 32'd48000;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE  = 4'd0;
   localparam logic [ERR_W-1:0] ERR_RIFF  = 4'd1;
   localparam logic [ERR_W-1:0] ERR_WAVE  = 4'd2;
   localparam logic [ERR_W-1:0] ERR_FMT   = 4'd3;
   localparam logic [ERR_W-1:0] ERR_PCM   = 4'd4;
   localparam logic [ERR_W-1:0] ERR_MONO  = 4'd5;
   localparam logic [ERR_W-1:0] ERR_RATE  = 4'd6;
   localparam logic [ERR_W-1:0] ERR_DEPTH = 4'd7;
   localparam logic [ERR_W-1:0] ERR_DATA  = 4'd8;

   // four-character tags as little-endian words
   localparam logic [ACC_W-1:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [ACC_W-1:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [ACC_W-1:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [ACC_W-1:0] TAG_DATA = 32'h6174_6164;

   // expected 16-bit header values
   localparam logic [15:0] FMT_PCM     = 16'd1;
   localparam logic [15:0] CHAN_MONO   = 16'd1;
   localparam logic [15:0] SAMPLE_BITS = 16'd16;

   // byte positions of the last byte of each checked field
   localparam logic [POS_W-1:0] POS_RIFF  = 6'd3;
   localparam logic [POS_W-1:0] POS_WAVE  = 6'd11;
   localparam logic [POS_W-1:0] POS_FMT   = 6'd15;
   localparam logic [POS_W-1:0] POS_PCM   = 6'd21;
   localparam logic [POS_W-1:0] POS_MONO  = 6'd23;
   localparam logic [POS_W-1:0] POS_RATE  = 6'd27;
   localparam logic [POS_W-1:0] POS_DEPTH = 6'd35;
   localparam logic [POS_W-1:0] POS_DATA  = 6'd39;
   localparam logic [POS_W-1:0] POS_LAST  = 6'd43;

endpackage

FILE: rtl/core/wavhp_if.sv
// Channel interfaces of the WAV header parser: byte input, result output, register write.
interface wavhp_req_if;
   logic                            valid;
   logic                            ready;
   logic [wavhp_pkg::BYTE_W-1:0]    data_byte;
   logic                            start_of_file;

   modport source (output valid, data_byte, start_of_file, input ready);
   modport sink   (input valid, data_byte, start_of_file, output ready);
endinterface

interface wavhp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [wavhp_pkg::KIND_W-1:0]    kind;
   logic [wavhp_pkg::FRAME_W-1:0]   frame_value;
   logic                            last_frame;
   logic [wavhp_pkg::COUNT_W-1:0]   frame_count;
   logic [wavhp_pkg::ERR_W-1:0]     error_code;

   modport source (output valid, kind, frame_value, last_frame, frame_count, error_code,
                   input ready);
   modport sink   (input valid, kind, frame_value, last_frame, frame_count, error_code,
                   output ready);
endinterface

interface wavhp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [wavhp_pkg::RATE_W-1:0]    wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

FILE: rtl/core/wav_header_parser_unit.sv
// WAV header parser: checks the canonical 44-byte PCM header and emits 16-bit frames.
// An accepted byte passes through the input register and then the result register to its result word.
// Throughput: one byte per cycle; the single-pass state update between the two registers
// sets it, and a stalled result register holds the byte stage until it drains.
// Reset (synchronous, active high): parser at header byte 0, both stages empty,
// expected sample rate back to 48000.
module wav_header_parser_unit (
   input logic        clock,
   input logic        reset,
   wavhp_req_if.sink   req_chan,
   wavhp_rsp_if.source rsp_chan,
   wavhp_csr_if.sink   csr_chan
);

   // parser phases
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_DATA   = 2'd1;
   localparam logic [1:0] PH_IDLE   = 2'd2;

   // unit steps at counter widths
   localparam logic [wavhp_pkg::POS_W-1:0]   POS_STEP   = {{(wavhp_pkg::POS_W-1){1'b0}}, 1'b1};
   localparam logic [wavhp_pkg::COUNT_W-1:0] FRAME_STEP = {{(wavhp_pkg::COUNT_W-1){1'b0}}, 1'b1};

   // configuration register
   logic [wavhp_pkg::RATE_W-1:0]  rate_ff;

   // input stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [wavhp_pkg::BYTE_W-1:0]  s1_byte_ff;
   logic                          s1_sof_ff;
   logic                          req_take;
   logic                          s1_advance;

   // parser state
   logic [wavhp_pkg::POS_W-1:0]   pos_ff, pos_in, pos_cur;
   logic [1:0]                    phase_ff, phase_in;
   logic [wavhp_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [wavhp_pkg::COUNT_W-1:0] frames_ff, frames_in;
   logic [wavhp_pkg::BYTE_W-1:0]  low_ff, low_in;
   logic                          parity_ff, parity_in;

   // result computed this cycle
   logic                          res_valid;
   logic [wavhp_pkg::KIND_W-1:0]  res_kind;
   logic [wavhp_pkg::FRAME_W-1:0] res_value;
   logic                          res_last;
   logic [wavhp_pkg::COUNT_W-1:0] res_count;
   logic [wavhp_pkg::ERR_W-1:0]   res_err;

   // result register
   logic                          out_valid_ff, out_valid_in;
   logic [wavhp_pkg::KIND_W-1:0]  out_kind_ff;
   logic [wavhp_pkg::FRAME_W-1:0] out_value_ff;
   logic                          out_last_ff;
   logic [wavhp_pkg::COUNT_W-1:0] out_count_ff;
   logic [wavhp_pkg::ERR_W-1:0]   out_err_ff;

   // handshakes: byte stage moves on when the result slot is free or draining
   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign s1_valid_in    = req_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   // sample rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= wavhp_pkg::RATE_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         rate_ff <= csr_chan.wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_sof_ff  <= req_chan.start_of_file;
      end
   end

   // one pass of the parser over the held byte
   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      frames_in = frames_ff;
      low_in    = low_ff;
      parity_in = parity_ff;
      pos_cur   = pos_ff;
      res_valid = 1'b0;
      res_kind  = wavhp_pkg::KIND_FRAME;
      res_value = '0;
      res_last  = 1'b0;
      res_count = '0;
      res_err   = wavhp_pkg::ERR_NONE;

      if (s1_advance) begin
         // start of file restarts the parser before the byte is used
         if (s1_sof_ff) begin
            pos_in    = '0;
            phase_in  = PH_HEADER;
            acc_in    = '0;
            frames_in = '0;
            low_in    = '0;
            parity_in = 1'b0;
         end
         pos_cur = pos_in;

         case (phase_in)
            PH_DATA: begin
               if (!parity_in) begin
                  low_in    = s1_byte_ff;
                  parity_in = 1'b1;
               end else begin
                  parity_in = 1'b0;
                  frames_in = frames_in - FRAME_STEP;
                  if (frames_in == '0) begin
                     phase_in = PH_IDLE;
                  end
                  res_valid = 1'b1;
                  res_kind  = wavhp_pkg::KIND_FRAME;
                  res_value = {s1_byte_ff, low_in};
                  res_last  = (frames_in == '0);
               end
            end
            PH_HEADER: begin
               acc_in = {s1_byte_ff, acc_in[wavhp_pkg::ACC_W-1:8]};
               pos_in = pos_cur + POS_STEP;
               case (pos_cur)
                  wavhp_pkg::POS_RIFF: begin
                     if (acc_in != wavhp_pkg::TAG_RIFF) begin
                        res_valid = 1'b1;
                        res_err   = wavhp_pkg::ERR_RIFF;
                     end
                  end
                  wavhp_pkg::POS_WAVE: begin
                     if (acc_in != wavhp_pkg::TAG_WAVE) begin
                        res_valid = 1'b1;
                        res_err   = wavhp_pkg::ERR_WAVE;
                     end
                  end
                  wavhp_pkg::POS_FMT: begin
                     if (acc_in != wavhp_pkg::TAG_FMT) begin
                        res_valid = 1'b1;
                        res_err   = wavhp_pkg::ERR_FMT;
                     end
                  end
                  wavhp_pkg::POS_PCM: begin
                     if (acc_in[31:16] != wavhp_pkg::FMT_PCM) begin
                        res_valid = 1'b1;
                        res_err   = wavhp_pkg::ERR_PCM;
                     end
                  end
                  wavhp_pkg::POS_MONO: begin
                     if (acc_in[31:16] != wavhp_pkg::CHAN_MONO) begin
                        res_valid = 1'b1;
                        res_err   = wavhp_pkg::ERR_MONO;
                     end
                  end
                  wavhp_pkg::POS_RATE: begin
                     if (acc_in != rate_ff) begin
                        res_valid = 1'b1;
                        res_err   = wavhp_pkg::ERR_RATE;
                     end
                  end
                  wavhp_pkg::POS_DEPTH: begin
                     if (acc_in[31:16] != wavhp_pkg::SAMPLE_BITS) begin
                        res_valid = 1'b1;
                        res_err   = wavhp_pkg::ERR_DEPTH;
                     end
                  end
                  wavhp_pkg::POS_DATA: begin
                     if (acc_in != wavhp_pkg::TAG_DATA) begin
                        res_valid = 1'b1;
                        res_err   = wavhp_pkg::ERR_DATA;
                     end
                  end
                  wavhp_pkg::POS_LAST: begin
                     // data size arrived: frame count is the size halved
                     frames_in = acc_in[wavhp_pkg::ACC_W-1:1];
                     parity_in = 1'b0;
                     low_in    = '0;
                     phase_in  = (frames_in == '0) ? PH_IDLE : PH_DATA;
                     res_valid = 1'b1;
                     res_kind  = wavhp_pkg::KIND_HEADER;
                     res_count = frames_in;
                  end
                  default: begin
                     if (pos_cur > wavhp_pkg::POS_LAST) begin
                        phase_in = PH_IDLE;
                     end
                  end
               endcase
               // any failed check ends the file
               if (res_valid && res_kind != wavhp_pkg::KIND_HEADER) begin
                  res_kind = wavhp_pkg::KIND_ERROR;
                  phase_in = PH_IDLE;
               end
            end
            default: ;  // idle, and the unused code, drop the byte
         endcase
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_HEADER;
         acc_ff    <= '0;
         frames_ff <= '0;
         low_ff    <= '0;
         parity_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         frames_ff <= frames_in;
         low_ff    <= low_in;
         parity_ff <= parity_in;
      end
   end

   // result register
   assign out_valid_in = res_valid ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (res_valid) begin
         out_kind_ff  <= res_kind;
         out_value_ff <= res_value;
         out_last_ff  <= res_last;
         out_count_ff <= res_count;
         out_err_ff   <= res_err;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_kind_ff;
   assign rsp_chan.frame_value = out_value_ff;
   assign rsp_chan.last_frame  = out_last_ff;
   assign rsp_chan.frame_count = out_count_ff;
   assign rsp_chan.error_code  = out_err_ff;

   // checks
   a_no_phase3: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("parser phase holds the unused code");

   a_data_has_frames: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> frames_ff != '0)
      else $error("data phase with no frames left");

   a_error_coded: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == wavhp_pkg::KIND_ERROR |-> out_err_ff != wavhp_pkg::ERR_NONE)
      else $error("header error word without an error code");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff && $stable(out_kind_ff))
      else $error("stalled result word was overwritten");

endmodule
